>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, reset disables every check
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/tbps_pkg.sv
// ---------------------------------------------------------------------------
// tbps_pkg
// types and constants of the token bucket packet shaper
// ---------------------------------------------------------------------------
package tbps_pkg;

  localparam int LEN_W     = 16;
  localparam int ELAPSED_W = 24;
  localparam int RATE_W    = 17;
  localparam int BUCKET_W  = 24;
  localparam int TOKEN_W   = 32;
  localparam int EVENT_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;
  localparam int PROD_W    = ELAPSED_W + RATE_W;
  localparam int BYTE_SHIFT = 3;
  localparam int ALU_W     = PROD_W - BYTE_SHIFT + 1;

  localparam logic [TOKEN_W-1:0] TOKEN_MAX = '1;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 17'd100;
  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 24'd32000;

  localparam logic [EVENT_W-1:0] EV_ACCEPTED = 2'd0;
  localparam logic [EVENT_W-1:0] EV_DROPPED  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_MUL,
    ST_ADD,
    ST_CHK,
    ST_RD,
    ST_FIN
  } state_t;

endpackage

>>> hdl/token_bucket_packet_shaper.sv
// ---------------------------------------------------------------------------
// token_bucket_packet_shaper
// token bucket shaper holding a queue of packet lengths
// ---------------------------------------------------------------------------
// Input beats carry op, packet_len and elapsed_us. An enqueue beat gives one
// result beat (accepted or dropped, last set). A tick beat steps through the
// multiply, the token add through the shared adder and a first check, then
// a read and a check per released packet, then a final step; it gives one
// released beat per packet, last set on the final one, and none when no
// packet can go. in_stall is high from the cycle after an accepted beat
// until that beat is done, and the next beat is taken in the idle state, so
// the block takes one input beat at a time.
// The shared 39-bit add/subtract unit does the token add, each head compare
// and subtract, and the bucket clamp compare; the length queue is a
// memory read at the head pointer with registered data.
// Results sit in an output register; while the receiver stalls, the block
// keeps working until it has a new beat to place, then waits.
// Configuration writes on cfg_we take effect at once and belong in idle
// time. Synchronous reset empties the queue, zeroes the tokens and restores
// rate 100 and bucket 32000; queue entries themselves are not cleared.
// ---------------------------------------------------------------------------
module token_bucket_packet_shaper #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [tbps_pkg::LEN_W-1:0]          in_packet_len,
  input  logic [tbps_pkg::ELAPSED_W-1:0]      in_elapsed_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tbps_pkg::EVENT_W-1:0]        out_event_res,
  output logic [tbps_pkg::LEN_W-1:0]          out_released_len,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbps_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  tbps_pkg::state_t state_r, state_nxt;

  logic [tbps_pkg::RATE_W-1:0]    rate_r;
  logic [tbps_pkg::BUCKET_W-1:0]  bucket_r;
  logic [tbps_pkg::TOKEN_W-1:0]   tokens_r, tokens_nxt;
  logic [PTR_W-1:0]               head_r, head_nxt;
  logic [PTR_W-1:0]               tail_r, tail_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic [tbps_pkg::LEN_W-1:0]     pend_len_r, pend_len_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [tbps_pkg::EVENT_W-1:0]   out_event_r, out_event_nxt;
  logic [tbps_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [tbps_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [tbps_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [tbps_pkg::PROD_W-1:0]    prod_r, prod_nxt;

  logic [tbps_pkg::LEN_W-1:0] mem [QUEUE_DEPTH];
  logic [tbps_pkg::LEN_W-1:0] rd_data_r;
  logic                       mem_we;

  // shared add/subtract unit
  logic [tbps_pkg::ALU_W-1:0] alu_a, alu_b, alu_y;
  logic                       alu_sub;
  logic                       borrow;

  logic accept;
  logic out_free;
  logic head_fits;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign alu_y    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign borrow   = alu_y[tbps_pkg::ALU_W-1];
  assign head_fits = (count_r != '0) && !borrow;

  always_comb begin
    alu_a   = tbps_pkg::ALU_W'(tokens_r);
    alu_b   = tbps_pkg::ALU_W'(rd_data_r);
    alu_sub = 1'b1;
    case (state_r)
      tbps_pkg::ST_ADD: begin
        alu_b   = tbps_pkg::ALU_W'(prod_r >> tbps_pkg::BYTE_SHIFT);
        alu_sub = 1'b0;
      end
      tbps_pkg::ST_FIN: begin
        alu_b = tbps_pkg::ALU_W'(bucket_r);
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_op ? tbps_pkg::ST_MUL : tbps_pkg::ST_ENQ;
        end
      end
      tbps_pkg::ST_ENQ: begin
        if (out_free) begin
          state_nxt = tbps_pkg::ST_IDLE;
        end
      end
      tbps_pkg::ST_MUL: state_nxt = tbps_pkg::ST_ADD;
      tbps_pkg::ST_ADD: state_nxt = tbps_pkg::ST_CHK;
      tbps_pkg::ST_CHK: begin
        if (!head_fits) begin
          state_nxt = tbps_pkg::ST_FIN;
        end else if (!pend_valid_r || out_free) begin
          state_nxt = tbps_pkg::ST_RD;
        end
      end
      tbps_pkg::ST_RD: state_nxt = tbps_pkg::ST_CHK;
      tbps_pkg::ST_FIN: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = tbps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbps_pkg::ST_IDLE;
    endcase
  end

  // datapath control and outputs
  always_comb begin
    in_stall       = (state_r != tbps_pkg::ST_IDLE);
    tokens_nxt     = tokens_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    pend_valid_nxt = pend_valid_r;
    pend_len_nxt   = pend_len_r;
    len_nxt        = len_r;
    elapsed_nxt    = elapsed_r;
    prod_nxt       = prod_r;
    mem_we         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_event_nxt  = out_event_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      tbps_pkg::ST_IDLE: begin
        if (accept) begin
          len_nxt     = in_packet_len;
          elapsed_nxt = in_elapsed_us;
        end
      end
      tbps_pkg::ST_ENQ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (count_r == CNT_FULL) begin
            out_event_nxt = tbps_pkg::EV_DROPPED;
          end else begin
            out_event_nxt = tbps_pkg::EV_ACCEPTED;
            mem_we        = 1'b1;
            tail_nxt      = ptr_inc(tail_r);
            count_nxt     = count_r + CNT_W'(1);
          end
        end
      end
      tbps_pkg::ST_MUL: begin
        prod_nxt = tbps_pkg::PROD_W'(elapsed_r) * tbps_pkg::PROD_W'(rate_r);
      end
      tbps_pkg::ST_ADD: begin
        if (alu_y[tbps_pkg::ALU_W-1:tbps_pkg::TOKEN_W] != '0) begin
          tokens_nxt = tbps_pkg::TOKEN_MAX;
        end else begin
          tokens_nxt = alu_y[tbps_pkg::TOKEN_W-1:0];
        end
      end
      tbps_pkg::ST_CHK: begin
        // a release is held back one step so the final one can carry last
        if (head_fits && (!pend_valid_r || out_free)) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_event_nxt = tbps_pkg::EV_RELEASED;
            out_len_nxt   = pend_len_r;
            out_last_nxt  = 1'b0;
          end
          tokens_nxt     = alu_y[tbps_pkg::TOKEN_W-1:0];
          head_nxt       = ptr_inc(head_r);
          count_nxt      = count_r - CNT_W'(1);
          pend_valid_nxt = 1'b1;
          pend_len_nxt   = rd_data_r;
        end
      end
      tbps_pkg::ST_FIN: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_event_nxt = tbps_pkg::EV_RELEASED;
            out_len_nxt   = pend_len_r;
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          if (count_r == '0 && !borrow) begin
            tokens_nxt = tbps_pkg::TOKEN_W'(bucket_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tbps_pkg::ST_IDLE;
      rate_r       <= tbps_pkg::RATE_RESET;
      bucket_r     <= tbps_pkg::BUCKET_RESET;
      tokens_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tokens_r     <= tokens_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tbps_pkg::CFG_RATE:   rate_r   <= cfg_wdata[tbps_pkg::RATE_W-1:0];
          tbps_pkg::CFG_BUCKET: bucket_r <= cfg_wdata[tbps_pkg::BUCKET_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_len_r  <= pend_len_nxt;
    out_event_r <= out_event_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
    len_r       <= len_nxt;
    elapsed_r   <= elapsed_nxt;
    prod_r      <= prod_nxt;
  end

  // length queue, read port always follows the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= len_r;
    end
    rd_data_r <= mem[head_r];
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_event_r;
  assign out_released_len = out_len_r;
  assign out_last         = out_last_r;

endmodule

>>> hdl/tbps_checker.sv
// ---------------------------------------------------------------------------
// tbps_checker
// port-level checks of the token bucket packet shaper
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tbps_pkg::EVENT_W-1:0] out_event_res,
  input logic [tbps_pkg::LEN_W-1:0]   out_released_len,
  input logic                         out_last
);

  logic [tbps_pkg::EVENT_W+tbps_pkg::LEN_W:0] out_payload;
  logic                                       is_release;
  logic                                       len_zero;
  logic                                       event_known;

  assign out_payload = {out_event_res, out_released_len, out_last};
  assign is_release  = (out_event_res == tbps_pkg::EV_RELEASED);
  assign len_zero    = (out_released_len == '0);
  assign event_known = (out_event_res == tbps_pkg::EV_ACCEPTED) ||
                       (out_event_res == tbps_pkg::EV_DROPPED) || is_release;

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // enqueue answers are single beats with no length
  `ASSERT_SAME(a_enq_answer, clk, rst_n, out_valid && !is_release, out_last && len_zero)

  // no unused event code
  `ASSERT_SAME(a_event_code, clk, rst_n, out_valid, event_known)

  // one item at a time: the beat after an accepted one is stalled
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind token_bucket_packet_shaper tbps_checker u_tbps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_res    (out_event_res),
  .out_released_len (out_released_len),
  .out_last         (out_last)
);

>>> verif/token_bucket_packet_shaper_checker.sv
// ---------------------------------------------------------------------------
// token_bucket_packet_shaper_checker
// watches the input, result and register ports of the shaper, keeps its own
// copy of the packet queue, the tokens and the registers, works out the
// result beats of every accepted input beat and compares each accepted
// result beat with the oldest one still due
// ---------------------------------------------------------------------------
module token_bucket_packet_shaper_checker
  import tbps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_op,
  input  logic [LEN_W-1:0]     in_packet_len,
  input  logic [ELAPSED_W-1:0] in_elapsed_us,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [EVENT_W-1:0]   out_event_res,
  input  logic [LEN_W-1:0]     out_released_len,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAX_LOG = 50;

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [LEN_W-1:0]   len;
    logic               last;
  } shaper_result_t;

  shaper_result_t due_results[$];

  logic [LEN_W-1:0]    len_store [QUEUE_DEPTH];
  logic [PTR_W-1:0]    head;
  logic [PTR_W:0]      queued;
  logic [TOKEN_W-1:0]  tokens;
  logic [RATE_W-1:0]   rate;
  logic [BUCKET_W-1:0] bucket;

  task automatic flag_mismatch(input string msg);
    if (fail_count < MAX_LOG) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic shape_enqueue(input logic [LEN_W-1:0] len);
    int tail;
    if (queued >= QUEUE_DEPTH) begin
      due_results.push_back('{ev: EV_DROPPED, len: '0, last: 1'b1});
    end else begin
      tail = (int'(head) + int'(queued)) % QUEUE_DEPTH;
      len_store[tail] = len;
      queued = queued + 1'b1;
      due_results.push_back('{ev: EV_ACCEPTED, len: '0, last: 1'b1});
    end
  endtask

  task automatic shape_tick(input logic [ELAPSED_W-1:0] elapsed);
    logic [PROD_W-1:0] gain;
    logic [SUM_W-1:0]  total;
    shaper_result_t    held;
    bit                holding;
    gain  = (PROD_W'(elapsed) * PROD_W'(rate)) >> BYTE_SHIFT;
    total = SUM_W'(gain) + SUM_W'(tokens);
    tokens = (total > SUM_W'(TOKEN_MAX)) ? TOKEN_MAX : total[TOKEN_W-1:0];
    holding = 1'b0;
    held = '0;
    // the last mark goes on the final release, so hold each beat back by one
    while (queued != 0 && TOKEN_W'(len_store[head]) <= tokens) begin
      if (holding) due_results.push_back(held);
      held = '{ev: EV_RELEASED, len: len_store[head], last: 1'b0};
      holding = 1'b1;
      tokens = tokens - TOKEN_W'(len_store[head]);
      head = (int'(head) == QUEUE_DEPTH - 1) ? '0 : head + 1'b1;
      queued = queued - 1'b1;
    end
    if (holding) begin
      held.last = 1'b1;
      due_results.push_back(held);
    end
    if (queued == 0 && tokens >= TOKEN_W'(bucket)) tokens = TOKEN_W'(bucket);
  endtask

  task automatic check_result();
    shaper_result_t want;
    if (due_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat: event %0d len %0d last %0b",
                              out_event_res, out_released_len, out_last));
      return;
    end
    want = due_results.pop_front();
    if (out_event_res !== want.ev)
      flag_mismatch($sformatf("event_res %0d, want %0d", out_event_res, want.ev));
    if (out_released_len !== want.len)
      flag_mismatch($sformatf("released_len %0d, want %0d", out_released_len, want.len));
    if (out_last !== want.last)
      flag_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      head   = '0;
      queued = '0;
      tokens = '0;
      rate   = RATE_RESET;
      bucket = BUCKET_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:   rate = cfg_wdata[RATE_W-1:0];
          CFG_BUCKET: bucket = cfg_wdata[BUCKET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_op) shape_tick(in_elapsed_us);
        else shape_enqueue(in_packet_len);
      end
      if (out_valid && !out_stall) check_result();
    end
    pending = due_results.size();
  end

endmodule

>>> verif/token_bucket_packet_shaper_test.sv
// ---------------------------------------------------------------------------
// token_bucket_packet_shaper_test
// testbench top: drives enqueue and tick beats and register writes
// ---------------------------------------------------------------------------
// A short directed run at the reset settings covers an empty tick, a
// zero-length packet, the largest packet and tick, the bucket clamp and a
// partial release. Random traffic then runs under several rate and bucket
// settings, the extremes among them, including a queue overrun and a tick
// that saturates the tokens and empties a full queue. The sender works in
// bursts with random gaps, the receiver stalls in changing modes, and the
// checker beside the block predicts and compares every result beat.
// ---------------------------------------------------------------------------
module token_bucket_packet_shaper_test;
  import tbps_pkg::*;

  localparam int DEPTH         = 64;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_RANDOM = 2'd1;
  localparam logic [1:0] STALL_BURST  = 2'd2;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_op         = OP_ENQUEUE;
  logic [LEN_W-1:0]     in_packet_len = '0;
  logic [ELAPSED_W-1:0] in_elapsed_us = '0;
  logic                 out_stall     = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_RATE;
  logic [CFG_DAT_W-1:0] cfg_wdata     = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [EVENT_W-1:0]   out_event_res;
  logic [LEN_W-1:0]     out_released_len;
  logic                 out_last;

  int fail_count;
  int pending;
  int burst_left  = 0;
  int idle_cycles = 0;

  logic [1:0] stall_mode = STALL_NONE;
  int         stall_span = 0;
  int         stall_hold = 0;

  token_bucket_packet_shaper #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_packet_len    (in_packet_len),
    .in_elapsed_us    (in_elapsed_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_released_len (out_released_len),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  token_bucket_packet_shaper_checker #(.QUEUE_DEPTH(DEPTH)) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_packet_len    (in_packet_len),
    .in_elapsed_us    (in_elapsed_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_released_len (out_released_len),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: no stalls, scattered stalls, or long stall bursts
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= 2'($urandom_range(STALL_NONE, STALL_BURST));
      stall_span <= $urandom_range(100, 400);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_hold != 0) begin
          stall_hold <= stall_hold - 1;
        end else begin
          out_stall  <= !out_stall;
          stall_hold <= out_stall ? $urandom_range(0, 7) : $urandom_range(0, 23);
        end
      end
    endcase
  end

  // watchdog: too long without any beat or register write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat; valid stays high inside a burst, drops for a gap after it
  task automatic push_beat(input logic op, input logic [LEN_W-1:0] len,
                           input logic [ELAPSED_W-1:0] elapsed);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_packet_len <= len;
    in_elapsed_us <= elapsed;
    do @(posedge clk); while (in_stall);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic enqueue(input logic [LEN_W-1:0] len);
    push_beat(OP_ENQUEUE, len, ELAPSED_W'($urandom_range(0, 24'hFFFFFF)));
  endtask

  task automatic tick(input logic [ELAPSED_W-1:0] elapsed);
    push_beat(OP_TICK, LEN_W'($urandom_range(0, 16'hFFFF)), elapsed);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is in and a tick with no release has finished
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] random_len();
    case ($urandom_range(0, 3))
      0:       return LEN_W'($urandom_range(0, 64));
      1:       return LEN_W'($urandom_range(0, 1500));
      2:       return LEN_W'($urandom_range(0, 9000));
      default: return LEN_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_elapsed();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ELAPSED_W'($urandom_range(0, 200));
      2:       return ELAPSED_W'($urandom_range(0, 5000));
      default: return ELAPSED_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic random_traffic(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 6) enqueue(random_len());
      else tick(random_elapsed());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: rate 100, bucket 32000
    tick('0);
    enqueue('0);
    tick('0);
    enqueue(16'hFFFF);
    enqueue(16'd1);
    tick(24'hFFFFFF);
    // tokens now clamped to the bucket, one byte short of this packet
    enqueue(16'd32001);
    tick('0);
    tick(24'd1);
    // 23 tokens: first packet goes, second waits
    enqueue(16'd5);
    enqueue(16'd20);
    tick(24'd1);
    tick('0);
    enqueue(16'hAAAA);
    enqueue(16'h5555);
    tick(24'h555555);
    tick(24'hAAAAAA);
    settle();
    random_traffic(20);
    settle();

    // nothing fills, clamp to zero
    set_reg(CFG_RATE, '0);
    set_reg(CFG_BUCKET, '0);
    random_traffic(10);
    settle();

    // rate written with all bits set, above the usual top rate
    set_reg(CFG_RATE, '1);
    set_reg(CFG_BUCKET, 24'hFFFFFF);
    repeat (DEPTH + 3) enqueue(random_len());
    tick(24'hFFFFFF);
    repeat (10) enqueue(random_len());
    tick(24'hFFFFFF);
    random_traffic(10);
    settle();

    set_reg(CFG_RATE, CFG_DAT_W'($urandom_range(1, 2000)));
    set_reg(CFG_BUCKET, CFG_DAT_W'($urandom_range(0, 100000)));
    random_traffic(12);
    settle();

    set_reg(CFG_RATE, CFG_DAT_W'(100000));
    set_reg(CFG_BUCKET, CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)));
    random_traffic(12);
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> token_bucket_packet_shaper.f
+incdir+hdl
hdl/tbps_pkg.sv
hdl/token_bucket_packet_shaper.sv
hdl/tbps_checker.sv
verif/token_bucket_packet_shaper_checker.sv
verif/token_bucket_packet_shaper_test.sv
